// ===== src/rrp_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_pkg
// Shared types and constants of the multibulk request parser.
// ----------------------------------------------------------------------------
package rrp_pkg;

  // Protocol characters
  localparam logic [7:0] CH_STAR   = 8'h2A;
  localparam logic [7:0] CH_DOLLAR = 8'h24;
  localparam logic [7:0] CH_CR     = 8'h0D;
  localparam logic [7:0] CH_LF     = 8'h0A;
  localparam logic [7:0] CH_ZERO   = 8'h30;
  localparam logic [7:0] CH_NINE   = 8'h39;

  // Result queue sizing
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_PTR_W = $clog2(FIFO_DEPTH);
  localparam int FIFO_CNT_W = $clog2(FIFO_DEPTH + 1);

  typedef enum logic [2:0] {
    EV_START = 3'd0,
    EV_LEN   = 3'd1,
    EV_PAY   = 3'd2,
    EV_DONE  = 3'd3,
    EV_FAIL  = 3'd4
  } ev_t;

  typedef enum logic [1:0] {
    CAUSE_HEADER = 2'd0,
    CAUSE_RANGE  = 2'd1,
    CAUSE_EOD    = 2'd2
  } cause_t;

  typedef struct packed {
    ev_t         event_res;
    logic [15:0] arg_count;
    logic [15:0] arg_index;
    logic [31:0] arg_length;
    logic [7:0]  payload_byte;
    logic        last_of_arg;
    cause_t      fail_cause;
    logic        last;
  } result_t;

endpackage

// ===== src/rrp_core.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_core
// Parser state and per-byte decode; emits up to two results per byte.
// ----------------------------------------------------------------------------
module rrp_core #(
  parameter int LEN_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             step,
  input  logic [7:0]       data_byte,
  input  logic             end_of_data,
  output logic [1:0]       n_res,
  output rrp_pkg::result_t res0,
  output rrp_pkg::result_t res1
);
  import rrp_pkg::*;

  localparam int ACC_W  = (LEN_BITS > COUNT_BITS) ? LEN_BITS : COUNT_BITS;
  localparam int PROD_W = ACC_W + 4;

  typedef enum logic [2:0] {
    PH_HUNT  = 3'd0,
    PH_COUNT = 3'd1,
    PH_LEN   = 3'd2,
    PH_PAY   = 3'd3,
    PH_TRAIL = 3'd4
  } phase_t;

  phase_t                phase_r, phase_nxt;
  logic [1:0]            lp_r, lp_nxt;
  logic [ACC_W-1:0]      acc_r, acc_nxt;
  logic [COUNT_BITS-1:0] cnt_r, cnt_nxt;
  logic [COUNT_BITS-1:0] cur_r, cur_nxt;
  logic [LEN_BITS-1:0]   left_r, left_nxt;
  logic [1:0]            trail_r, trail_nxt;

  logic [PROD_W-1:0]     prod;
  logic                  is_count;
  logic                  too_big;
  logic                  is_digit;
  logic [7:0]            marker;
  logic [COUNT_BITS-1:0] cur_inc;
  result_t               r0, r1;

  // acc*10 + digit, then range check against the field's width
  assign prod = ({{4{1'b0}}, acc_r} << 3) + ({{4{1'b0}}, acc_r} << 1)
              + PROD_W'(data_byte - CH_ZERO);
  assign is_count = (phase_r == PH_COUNT);
  assign too_big  = is_count ? ((prod >> COUNT_BITS) != '0) : ((prod >> LEN_BITS) != '0);
  assign is_digit = (data_byte >= CH_ZERO) && (data_byte <= CH_NINE);
  assign marker   = is_count ? CH_STAR : CH_DOLLAR;
  assign cur_inc  = cur_r + 1'b1;

  always_comb begin
    phase_nxt = phase_r;
    lp_nxt    = lp_r;
    acc_nxt   = acc_r;
    cnt_nxt   = cnt_r;
    cur_nxt   = cur_r;
    left_nxt  = left_r;
    trail_nxt = trail_r;
    n_res     = 2'd0;
    r0        = '0;
    r1        = '0;

    if (end_of_data) begin
      if (phase_r == PH_COUNT || phase_r == PH_LEN || phase_r == PH_PAY ||
          phase_r == PH_TRAIL) begin
        n_res           = 2'd1;
        r0.event_res    = EV_FAIL;
        r0.arg_count    = 16'(cnt_r);
        r0.arg_index    = 16'(cur_r);
        r0.fail_cause   = CAUSE_EOD;
      end
      phase_nxt = PH_HUNT;
      lp_nxt    = 2'd0;
      if (phase_r == PH_HUNT) begin
        lp_nxt = lp_r;
      end
    end else begin
      unique case (phase_r)
        PH_COUNT, PH_LEN: begin
          logic bad, big, done;
          bad  = 1'b0;
          big  = 1'b0;
          done = 1'b0;
          unique case (lp_r)
            2'd0: begin
              if (data_byte != marker) bad = 1'b1;
              else lp_nxt = 2'd1;
            end
            2'd1: begin
              if (is_digit) begin
                if (too_big) big = 1'b1;
                else acc_nxt = prod[ACC_W-1:0];
              end else if (data_byte == CH_CR) begin
                lp_nxt = 2'd2;
              end else begin
                bad = 1'b1;
              end
            end
            default: begin
              if (data_byte == CH_LF) done = 1'b1;
              else bad = 1'b1;
            end
          endcase

          if (bad || big) begin
            n_res         = 2'd1;
            r0.event_res  = EV_FAIL;
            r0.arg_count  = 16'(cnt_r);
            r0.arg_index  = 16'(cur_r);
            r0.fail_cause = big ? CAUSE_RANGE : CAUSE_HEADER;
            phase_nxt     = PH_HUNT;
            lp_nxt        = 2'd0;
          end else if (done && is_count) begin
            cnt_nxt      = acc_r[COUNT_BITS-1:0];
            n_res        = 2'd1;
            r0.event_res = EV_START;
            r0.arg_count = 16'(acc_r[COUNT_BITS-1:0]);
            if (acc_r[COUNT_BITS-1:0] == '0) begin
              // empty request: start and done from the same byte
              n_res        = 2'd2;
              r1.event_res = EV_DONE;
              r1.arg_count = 16'(acc_r[COUNT_BITS-1:0]);
              phase_nxt    = PH_HUNT;
              lp_nxt       = 2'd0;
            end else begin
              phase_nxt = PH_LEN;
              lp_nxt    = 2'd0;
              acc_nxt   = '0;
            end
          end else if (done) begin
            left_nxt      = acc_r[LEN_BITS-1:0];
            n_res         = 2'd1;
            r0.event_res  = EV_LEN;
            r0.arg_count  = 16'(cnt_r);
            r0.arg_index  = 16'(cur_r);
            r0.arg_length = 32'(acc_r);
            lp_nxt        = 2'd0;
            if (acc_r[LEN_BITS-1:0] == '0) begin
              phase_nxt = PH_TRAIL;
              trail_nxt = 2'd2;
            end else begin
              phase_nxt = PH_PAY;
            end
          end
        end

        PH_PAY: begin
          logic [LEN_BITS-1:0] rem;
          rem = (left_r != '0) ? left_r - 1'b1 : left_r;
          left_nxt        = rem;
          n_res           = 2'd1;
          r0.event_res    = EV_PAY;
          r0.arg_count    = 16'(cnt_r);
          r0.arg_index    = 16'(cur_r);
          r0.arg_length   = 32'(acc_r);
          r0.payload_byte = data_byte;
          r0.last_of_arg  = (rem == '0);
          if (rem == '0) begin
            phase_nxt = PH_TRAIL;
            trail_nxt = 2'd2;
          end
        end

        PH_TRAIL: begin
          logic [1:0] t;
          t = (trail_r != 2'd0) ? trail_r - 2'd1 : trail_r;
          trail_nxt = t;
          if (t == 2'd0) begin
            cur_nxt = cur_inc;
            if (cur_inc >= cnt_r) begin
              n_res        = 2'd1;
              r0.event_res = EV_DONE;
              r0.arg_count = 16'(cnt_r);
              phase_nxt    = PH_HUNT;
              lp_nxt       = 2'd0;
            end else begin
              phase_nxt = PH_LEN;
              lp_nxt    = 2'd0;
              acc_nxt   = '0;
            end
          end
        end

        default: begin
          // hunting, and any stray phase code behaves the same
          phase_nxt = PH_HUNT;
          if (phase_r != PH_HUNT) lp_nxt = 2'd0;
          if (data_byte == CH_STAR) begin
            cnt_nxt   = '0;
            cur_nxt   = '0;
            acc_nxt   = '0;
            left_nxt  = '0;
            trail_nxt = 2'd0;
            lp_nxt    = 2'd1;
            phase_nxt = PH_COUNT;
          end
        end
      endcase
    end

    if (n_res == 2'd2) r1.last = 1'b1;
    else if (n_res == 2'd1) r0.last = 1'b1;
  end

  assign res0 = r0;
  assign res1 = r1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= PH_HUNT;
      lp_r    <= 2'd0;
      acc_r   <= '0;
      cnt_r   <= '0;
      cur_r   <= '0;
      left_r  <= '0;
      trail_r <= 2'd0;
    end else if (step) begin
      phase_r <= phase_nxt;
      lp_r    <= lp_nxt;
      acc_r   <= acc_nxt;
      cnt_r   <= cnt_nxt;
      cur_r   <= cur_nxt;
      left_r  <= left_nxt;
      trail_r <= trail_nxt;
    end
  end

endmodule

// ===== src/rrp_out_fifo.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rrp_out_fifo
// Small result queue: takes up to two words per cycle, hands out one.
// ----------------------------------------------------------------------------
module rrp_out_fifo (
  input  logic             clk,
  input  logic             rst_n,
  input  logic [1:0]       n_push,
  input  rrp_pkg::result_t push0,
  input  rrp_pkg::result_t push1,
  output logic             has_room,
  output logic             out_valid,
  input  logic             out_ready,
  output rrp_pkg::result_t out_word
);
  import rrp_pkg::*;

  result_t                 mem_r [FIFO_DEPTH];
  logic [FIFO_PTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [FIFO_PTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [FIFO_CNT_W-1:0]   count_r, count_nxt;
  logic [FIFO_PTR_W-1:0]   wr_ptr_p1;
  logic                    pop;

  assign pop        = out_valid && out_ready;
  assign out_valid  = (count_r != '0);
  assign out_word   = mem_r[rd_ptr_r];
  // room for a worst-case byte (two words)
  assign has_room   = (count_r <= FIFO_CNT_W'(FIFO_DEPTH - 2));
  assign wr_ptr_p1  = wr_ptr_r + 1'b1;

  assign wr_ptr_nxt = wr_ptr_r + FIFO_PTR_W'(n_push);
  assign rd_ptr_nxt = rd_ptr_r + FIFO_PTR_W'(pop);
  assign count_nxt  = count_r + FIFO_CNT_W'(n_push) - FIFO_CNT_W'(pop);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (n_push != 2'd0) mem_r[wr_ptr_r] <= push0;
    if (n_push == 2'd2) mem_r[wr_ptr_p1] <= push1;
  end

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= FIFO_CNT_W'(FIFO_DEPTH))
    else $error("result queue count out of range");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    (n_push != 2'd0) |->
      ((FIFO_CNT_W + 1)'(count_r) + (FIFO_CNT_W + 1)'(n_push) <= (FIFO_CNT_W + 1)'(FIFO_DEPTH)))
    else $error("result queue overrun");

  a_pop_only: assert property (@(posedge clk) disable iff (!rst_n)
    (pop && n_push == 2'd0) |=> (count_r == $past(count_r) - 1'b1))
    else $error("result queue count did not drop on pop");

endmodule

// ===== src/resp_request_parser.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// resp_request_parser
// Byte-serial multibulk request parser with a streaming result port.
// ----------------------------------------------------------------------------
// Takes one stream byte per clock and decodes it in the same cycle against
// the parser state; the events it causes (none, one, or two for a request with a
// zero count) go into a four-word result queue that drives the out_ port.
// The input accepts a byte every cycle while the queue has room for two
// words, so with the output side always ready the rate is one byte per
// clock; an empty request adds one extra output word. in_tlast marks end of
// stream: a request in progress then reports a failure.
// ----------------------------------------------------------------------------
module resp_request_parser #(
  parameter int LEN_BITS   = 32,
  parameter int COUNT_BITS = 16
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] data_byte
  input  logic        in_tlast,   // end_of_data
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [79:0] out_tdata,  // arg_count, arg_index, arg_length, payload_byte,
                                  // last_of_arg, fail_cause, zero fill
  output logic [2:0]  out_tuser,  // event_res
  output logic        out_tlast   // last word caused by this byte
);
  import rrp_pkg::*;

  logic       step;
  logic [1:0] n_res;
  logic       has_room;
  result_t    res0, res1, head;

  assign in_tready = has_room;
  assign step      = in_tvalid && in_tready;

  rrp_core #(
    .LEN_BITS   (LEN_BITS),
    .COUNT_BITS (COUNT_BITS)
  ) u_core (
    .clk         (clk),
    .rst_n       (rst_n),
    .step        (step),
    .data_byte   (in_tdata),
    .end_of_data (in_tlast),
    .n_res       (n_res),
    .res0        (res0),
    .res1        (res1)
  );

  rrp_out_fifo u_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .n_push    (step ? n_res : 2'd0),
    .push0     (res0),
    .push1     (res1),
    .has_room  (has_room),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_word  (head)
  );

  assign out_tdata = {5'd0, head.fail_cause, head.last_of_arg, head.payload_byte,
                      head.arg_length, head.arg_index, head.arg_count};
  assign out_tuser = head.event_res;
  assign out_tlast = head.last;

endmodule
